// ===== sv/lcgx_pkg.sv =====
// Shared constants, types and helper functions of the LCG key XOR stream cipher.
package lcgx_pkg;

  localparam int KEY_LENGTH = 32;
  localparam int POS_W      = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;

  localparam logic [31:0] LCG_MUL = 32'd214013;
  localparam logic [31:0] LCG_ADD = 32'd2531011;

  localparam logic [6:0] CHARSET_SIZE = 7'd61;
  localparam logic [5:0] UPPER_BASE   = 6'd26;
  localparam logic [5:0] DIGIT_BASE   = 6'd52;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_ONE     = 7'h31;

  // Control from the top level to the key generator for one request.
  typedef struct packed {
    logic restart;  // first byte of a message: start from the seed
    logic advance;  // a fresh key character is consumed this cycle
  } gen_ctrl_t;

  // One step of the linear congruential generator, modulo 2^32.
  function automatic logic [31:0] lcg_step(input logic [31:0] x);
    lcg_step = x * LCG_MUL + LCG_ADD;
  endfunction

  // Remainder of a 15-bit value by 61, using 64 = 3 (mod 61) to fold
  // the high bits down, then one final correction.
  function automatic logic [5:0] mod61(input logic [14:0] x);
    logic [10:0] s1;
    logic [7:0]  s2;
    logic [6:0]  s3;
    s1 = 11'(x[14:6]) * 11'd3 + 11'(x[5:0]);
    s2 = 8'(s1[10:6]) * 8'd3 + 8'(s1[5:0]);
    s3 = 7'(s2[7:6]) * 7'd3 + 7'(s2[5:0]);
    if (s3 >= CHARSET_SIZE) begin
      s3 = s3 - CHARSET_SIZE;
    end
    mod61 = s3[5:0];
  endfunction

  // Alphanumeric table: lower case, upper case, then the digits 1 to 9.
  function automatic logic [6:0] charset_char(input logic [5:0] idx);
    if (idx < UPPER_BASE) begin
      charset_char = CHAR_LOWER_A + 7'(idx);
    end else if (idx < DIGIT_BASE) begin
      charset_char = CHAR_UPPER_A + 7'(idx - UPPER_BASE);
    end else begin
      charset_char = CHAR_ONE + 7'(idx - DIGIT_BASE);
    end
  endfunction

endpackage

// ===== sv/lcgx_key_cell.sv =====
// One cell of the key ring: a key character register fed by its neighbour.
module lcgx_key_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [6:0] din,
  output logic [6:0] dout
);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

// ===== sv/lcgx_keygen.sv =====
// Key character generator: advanced LCG state and the character it selects.
module lcgx_keygen (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [31:0]        cfg_wdata,
  input  lcgx_pkg::gen_ctrl_t ctrl,
  output logic [6:0]         key_char
);
  import lcgx_pkg::*;

  // Both registers hold a state that has already been stepped once, so the
  // character of the current request needs no multiply in its path.
  logic [31:0] seed_adv;
  logic [31:0] state;
  logic [31:0] cur;

  assign cur      = ctrl.restart ? seed_adv : state;
  assign key_char = charset_char(mod61(cur[30:16]));

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_adv <= lcg_step(32'd0);
    end else if (cfg_wen) begin
      seed_adv <= lcg_step(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      state <= lcg_step(cur);
    end
  end

endmodule

// ===== sv/lcg_key_xor_stream_cipher_core.sv =====
// Top level of the LCG key XOR stream cipher: control, key ring and output buffer.
//
// Each byte of the stream is XORed with one character of a 32-character key.
// The key is built from the seed register by the generator
// state = state*214013 + 2531011, taking ((state>>16)&0x7fff) mod 61 as an
// index into the table a-z, A-Z, 1-9. During the first 32 bytes of a message
// each byte steps the generator and its character is shifted into a ring of
// key cells; after that the ring simply rotates, one cell per byte, and the
// character at its head is reused. A request with tlast set ends the message,
// and the next request starts again from the seed. The seed may be written
// at any time the block is idle and takes effect at the next message start.
// The block takes one request per clock cycle while its output buffer has a
// free entry: each result is registered into the two-entry output buffer when
// its request is accepted, and the buffer lets requests keep flowing while a
// result waits to be taken. The rate is set by the generator loop, one constant
// multiply and add per cycle; the mod 61 and table lookup act on the registered,
// already stepped state. There is no start-up pass after reset.
module lcg_key_xor_stream_cipher_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration: seed register.
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  // Slave side.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  // Master side.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast
);
  import lcgx_pkg::*;

  // Message and key position control.
  logic             message_start;
  logic [POS_W-1:0] pos;
  logic             complete;
  logic [POS_W-1:0] pos_eff;
  logic             complete_eff;
  logic             wrap;
  logic             generate_char;
  logic             s_acc;
  logic             m_acc;

  gen_ctrl_t  gen_ctrl;
  logic [6:0] new_char;
  logic [6:0] kc;

  // Key ring: cell 0 is the head, the current character re-enters at the tail.
  logic [6:0] ring [KEY_LENGTH];

  // Output buffer of two entries.
  logic [7:0] buf_data [2];
  logic       buf_last [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  // At a message start the position and completion state begin afresh.
  assign pos_eff       = message_start ? '0 : pos;
  assign complete_eff  = message_start ? 1'b0 : complete;
  assign wrap          = (pos_eff == POS_W'(KEY_LENGTH - 1));
  assign generate_char = !complete_eff;

  assign gen_ctrl.restart = message_start;
  assign gen_ctrl.advance = s_acc && generate_char;

  lcgx_keygen u_keygen (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .ctrl      (gen_ctrl),
    .key_char  (new_char)
  );

  assign kc = generate_char ? new_char : ring[0];

  // Every accepted request shifts the ring by one cell, so after a full key
  // the head again holds the character of key position zero.
  for (genvar i = 0; i < KEY_LENGTH; i++) begin : g_ring
    if (i == KEY_LENGTH - 1) begin : g_tail
      lcgx_key_cell u_cell (
        .clk   (clk),
        .shift (s_acc),
        .din   (kc),
        .dout  (ring[i])
      );
    end else begin : g_body
      lcgx_key_cell u_cell (
        .clk   (clk),
        .shift (s_acc),
        .din   (ring[i+1]),
        .dout  (ring[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_start <= 1'b1;
      pos           <= '0;
      complete      <= 1'b0;
    end else if (s_acc) begin
      message_start <= s_tlast;
      pos           <= wrap ? '0 : pos_eff + POS_W'(1);
      complete      <= complete_eff || wrap;
    end
  end

  // The slave side stays open while the buffer has a free entry, whatever
  // the master side does in the same cycle.
  assign s_tready = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = buf_data[rd_ptr];
  assign m_tlast  = buf_last[rd_ptr];

  always_ff @(posedge clk) begin
    if (s_acc) begin
      buf_data[wr_ptr] <= s_tdata ^ {1'b0, kc};
      buf_last[wr_ptr] <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (s_acc) begin
        wr_ptr <= !wr_ptr;
      end
      if (m_acc) begin
        rd_ptr <= !rd_ptr;
      end
      if (s_acc && !m_acc) begin
        count <= count + 2'd1;
      end else if (m_acc && !s_acc) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== bench/tb_lcg_key_xor_stream_cipher_core.sv =====
// Self-checking testbench for the LCG key XOR stream cipher core.
module tb_lcg_key_xor_stream_cipher_core;

  import lcgx_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYCLES = 11;
  localparam int LIMIT_CYCLES = 400000;
  localparam int STALL_CYCLES = 150;
  localparam int MAX_SHOWN    = 10;

  // Generator constants, held here so the prediction does not lean on the design.
  localparam logic [31:0] GEN_MUL = 32'd214013;
  localparam logic [31:0] GEN_INC = 32'd2531011;

  // One expected result: the transformed byte and the end-of-message flag.
  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } cipher_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] data_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] out_byte
  logic        m_tlast;

  lcg_key_xor_stream_cipher_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // The cipher as the bench sees it: seed register, generator, key cells and
  // the message bookkeeping, all updated once per accepted request.
  logic [31:0]      seed_model   = '0;
  logic [31:0]      lcg_model    = '0;
  logic [6:0]       key_cells [KEY_LENGTH];
  logic [POS_W-1:0] key_idx      = '0;
  logic             key_filled   = 1'b0;
  logic             at_msg_start = 1'b1;

  cipher_out_t pending_cipher[$];

  // Idle percentages for each side, and the long receiver stall requests.
  int src_idle = 0;
  int sink_idle = 0;
  int stall_orders = 0;
  int stall_served = 0;
  int hold_off_left = 0;

  int faults = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int msgs_closed = 0;
  int seed_loads = 0;

  // Maps a generator state to its alphanumeric key character.
  function automatic logic [6:0] key_char_of(input logic [31:0] st);
    int unsigned r;
    logic [7:0]  c;
    r = ((st >> 16) & 32'h7fff) % 61;
    if (r < 26) begin
      c = 8'd97 + 8'(r);
    end else if (r < 52) begin
      c = 8'd65 + 8'(r - 26);
    end else begin
      c = 8'd49 + 8'(r - 52);
    end
    key_char_of = c[6:0];
  endfunction

  // Works out the result of one accepted request and advances the key state.
  function automatic cipher_out_t encrypt_byte(input logic [7:0] b, input logic l);
    logic [6:0]  kc;
    cipher_out_t r;
    if (at_msg_start) begin
      lcg_model    = seed_model;
      key_idx      = '0;
      key_filled   = 1'b0;
      at_msg_start = 1'b0;
    end
    if (!key_filled) begin
      lcg_model         = lcg_model * GEN_MUL + GEN_INC;
      kc                = key_char_of(lcg_model);
      key_cells[key_idx] = kc;
    end else begin
      kc = key_cells[key_idx];
    end
    if (key_idx == POS_W'(KEY_LENGTH - 1)) begin
      key_idx    = '0;
      key_filled = 1'b1;
    end else begin
      key_idx = key_idx + POS_W'(1);
    end
    if (l) begin
      at_msg_start = 1'b1;
    end
    r.text = b ^ {1'b0, kc};
    r.last = l;
    encrypt_byte = r;
  endfunction

  // Offers one request, with random idle cycles ahead of it, and records the
  // expected result once it is accepted. Valid is left high on acceptance so
  // that back-to-back requests never lower and raise it in the same step.
  task automatic offer_request(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tlast  <= 1'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    pending_cipher.push_back(encrypt_byte(b, l));
    bytes_sent++;
    if (l) begin
      msgs_closed++;
    end
  endtask

  // Writes the seed register once the block has gone quiet: every expected
  // result taken, followed by a short wait for the output stage to settle.
  task automatic load_seed(input logic [31:0] v);
    s_tvalid <= 1'b0;
    while (pending_cipher.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    seed_model = v;
    seed_loads++;
  endtask

  // Receiver: checks each accepted result against the oldest expectation and
  // chooses the ready level for the next cycle, serving long stalls on request.
  always @(posedge clk) begin : rx_side
    cipher_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cipher.size() == 0) begin
        faults++;
        if (faults <= MAX_SHOWN) begin
          $display("Unexpected result: byte %02h last %0b with nothing pending",
                   m_tdata, m_tlast);
        end
      end else begin
        want = pending_cipher.pop_front();
        results_checked++;
        if (m_tdata !== want.text || m_tlast !== want.last) begin
          faults++;
          if (faults <= MAX_SHOWN) begin
            $display("Mismatch on result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                     results_checked, want.text, want.last, m_tdata, m_tlast);
          end
        end
      end
    end
    if (stall_orders != stall_served) begin
      stall_served  = stall_orders;
      hold_off_left = STALL_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  // Seed left at its reset value of zero, with the byte extremes.
  task automatic test_reset_seed();
    offer_request(8'h00, 1'b0);
    offer_request(8'hff, 1'b0);
    offer_request(8'ha5, 1'b0);
    offer_request(8'h5a, 1'b1);
  endtask

  // Every request closes its message, so each uses the first key character.
  task automatic test_last_on_every_byte();
    load_seed(32'h1234_5678);
    for (int k = 0; k < 4; k++) begin
      offer_request(8'($urandom), 1'b1);
    end
  endtask

  // A seed written inside a message must wait for the next message start.
  task automatic test_seed_change_mid_message();
    load_seed(32'hffff_ffff);
    offer_request(8'hff, 1'b0);
    offer_request(8'h00, 1'b0);
    offer_request(8'h81, 1'b0);
    load_seed(32'h0000_0001);
    offer_request(8'h7e, 1'b0);
    offer_request(8'h3c, 1'b1);
    offer_request(8'hc3, 1'b0);
    offer_request(8'h01, 1'b1);
  endtask

  // Seed with only the top bit set.
  task automatic test_seed_top_bit();
    load_seed(32'h8000_0000);
    offer_request(8'($urandom), 1'b0);
    offer_request(8'($urandom), 1'b0);
    offer_request(8'($urandom), 1'b1);
  endtask

  // A message well past the key length, so the stored key is reused in full and then again in part.
  task automatic test_key_wrap();
    load_seed($urandom);
    for (int k = 0; k < 2 * KEY_LENGTH + 6; k++) begin
      offer_request(8'($urandom), k == 2 * KEY_LENGTH + 5);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the output buffer fills and the block must stall its slave side.
  task automatic test_back_pressure();
    src_idle  = 0;
    sink_idle = 0;
    load_seed($urandom);
    stall_orders++;
    for (int k = 0; k < 48; k++) begin
      offer_request(8'($urandom), k == 47);
    end
  endtask

  // Random messages under one idle mix: mostly well-formed messages of varied
  // length, some around the key length or far past it, some noise with random
  // last flags, a few without a closing last, and seed loads between them.
  task automatic run_traffic(input int n_items, input int src_pct, input int sink_pct);
    int          sent;
    int          len;
    int          mode;
    logic        l;
    logic [31:0] v;
    src_idle  = src_pct;
    sink_idle = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0000_0000;
          1:       v = 32'hffff_ffff;
          2:       v = 32'h8000_0000;
          default: v = $urandom;
        endcase
        load_seed(v);
      end
      mode = $urandom_range(0, 9);
      case (mode) inside
        [0:4]:   len = $urandom_range(1, 40);
        [5:6]:   len = $urandom_range(KEY_LENGTH - 2, KEY_LENGTH + 2);
        7:       len = $urandom_range(60, 100);
        default: len = $urandom_range(1, 3);
      endcase
      for (int k = 0; k < len; k++) begin
        if (mode == 9) begin
          l = 1'($urandom);
        end else begin
          l = (k == len - 1) && ($urandom_range(0, 9) != 0);
        end
        offer_request(8'($urandom), l);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_seed();
    test_last_on_every_byte();
    test_seed_change_mid_message();
    test_seed_top_bit();
    test_key_wrap();
    test_back_pressure();
    load_seed(32'hffff_ffff);
    run_traffic(620, 16, 82);
    run_traffic(620, 82, 16);
    run_traffic(620, 0, 0);

    s_tvalid <= 1'b0;
    while (pending_cipher.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Covered %0d bytes, %0d closed messages and %0d seed loads; %0d results checked.",
             bytes_sent, msgs_closed, seed_loads, results_checked);
    $display("Idle mixes: sender-light, receiver-light, none, plus one long receiver stall.");
    if (faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d faults found.", faults);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("Run timed out with %0d results still pending.", pending_cipher.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lcgx_pkg.sv
sv/lcgx_key_cell.sv
sv/lcgx_keygen.sv
sv/lcg_key_xor_stream_cipher_core.sv
bench/tb_lcg_key_xor_stream_cipher_core.sv
